// ===== rtl/cfe_pkg.sv =====
// Package for the condition force effect unit.
// Holds the configuration struct, effect kind codes and register indexes.
// No dependencies.
`timescale 1ns / 1ps

package cfe_pkg;

  localparam logic [1:0] KIND_SPRING   = 2'd0;
  localparam logic [1:0] KIND_DAMPER   = 2'd1;
  localparam logic [1:0] KIND_INERTIA  = 2'd2;
  localparam logic [1:0] KIND_FRICTION = 2'd3;

  localparam logic [2:0] REG_EFFECT_KIND    = 3'd0;
  localparam logic [2:0] REG_CENTER_OFFSET  = 3'd1;
  localparam logic [2:0] REG_DEAD_BAND      = 3'd2;
  localparam logic [2:0] REG_POSITIVE_GAIN  = 3'd3;
  localparam logic [2:0] REG_NEGATIVE_GAIN  = 3'd4;
  localparam logic [2:0] REG_POSITIVE_LIMIT = 3'd5;
  localparam logic [2:0] REG_NEGATIVE_LIMIT = 3'd6;

  localparam int AddrWidth  = 5;
  localparam int ForceWidth = 19;

  typedef struct packed {
    logic [1:0]         effect_kind;
    logic signed [15:0] center_offset;
    logic [14:0]        dead_band;
    logic signed [15:0] positive_gain;
    logic signed [15:0] negative_gain;
    logic [14:0]        positive_limit;
    logic [14:0]        negative_limit;
  } cfe_cfg_t;

endpackage

// ===== rtl/cfe_cfg_regs.sv =====
// Configuration register file with an APB-style write and read port.
// Depends on cfe_pkg for the register indexes and the configuration struct.
`timescale 1ns / 1ps

module cfe_cfg_regs
  import cfe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output cfe_cfg_t             cfg
);

  cfe_cfg_t   cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[AddrWidth-1:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_EFFECT_KIND:    cfg_r.effect_kind    <= pwdata[1:0];
        REG_CENTER_OFFSET:  cfg_r.center_offset  <= pwdata[15:0];
        REG_DEAD_BAND:      cfg_r.dead_band      <= pwdata[14:0];
        REG_POSITIVE_GAIN:  cfg_r.positive_gain  <= pwdata[15:0];
        REG_NEGATIVE_GAIN:  cfg_r.negative_gain  <= pwdata[15:0];
        REG_POSITIVE_LIMIT: cfg_r.positive_limit <= pwdata[14:0];
        REG_NEGATIVE_LIMIT: cfg_r.negative_limit <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_EFFECT_KIND:    prdata = {30'd0, cfg_r.effect_kind};
      REG_CENTER_OFFSET:  prdata = {16'd0, cfg_r.center_offset};
      REG_DEAD_BAND:      prdata = {17'd0, cfg_r.dead_band};
      REG_POSITIVE_GAIN:  prdata = {16'd0, cfg_r.positive_gain};
      REG_NEGATIVE_GAIN:  prdata = {16'd0, cfg_r.negative_gain};
      REG_POSITIVE_LIMIT: prdata = {17'd0, cfg_r.positive_limit};
      REG_NEGATIVE_LIMIT: prdata = {17'd0, cfg_r.negative_limit};
      default:            prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/cfe_force_calc.sv =====
// Combinational force rule for one axis sample: banded spring, damper and
// inertia rules and the friction ramp. Depends on cfe_pkg.
`timescale 1ns / 1ps

module cfe_force_calc
  import cfe_pkg::*;
#(
  parameter int SPRING_EXTRA_DEAD_ZONE = 0
) (
  input  cfe_cfg_t                cfg,
  input  logic signed [15:0]      axis_position,
  input  logic signed [15:0]      axis_velocity,
  input  logic signed [15:0]      axis_acceleration,
  output logic [ForceWidth-1:0]   force_res
);

  logic [15:0]        spring_db;
  logic [15:0]        db;
  logic signed [15:0] x;
  logic signed [17:0] x_ext;
  logic signed [17:0] lo;
  logic signed [17:0] hi;
  logic               below;
  logic               above;
  logic signed [17:0] diff;
  logic signed [15:0] gain;
  logic signed [33:0] prod;
  logic signed [33:0] shifted;
  logic [14:0]        lim;
  logic signed [33:0] lim_pos;
  logic signed [33:0] lim_neg;
  logic               no_clamp;
  logic signed [33:0] clamped;
  logic signed [33:0] banded;
  logic               sign_equal;

  logic signed [17:0] vel_ext;
  logic signed [17:0] fr_t;
  logic signed [16:0] fr_coef;
  logic signed [26:0] fr_prod;
  logic signed [18:0] fr_force;

  assign spring_db = 16'({1'b0, cfg.dead_band} + 16'(SPRING_EXTRA_DEAD_ZONE));

  always_comb begin
    unique case (cfg.effect_kind)
      KIND_SPRING:  x = axis_position;
      KIND_INERTIA: x = axis_acceleration;
      default:      x = axis_velocity;
    endcase
    db = (cfg.effect_kind == KIND_SPRING) ? spring_db : {1'b0, cfg.dead_band};

    x_ext = {{2{x[15]}}, x};
    lo    = {{2{cfg.center_offset[15]}}, cfg.center_offset} - $signed({2'b00, db});
    hi    = {{2{cfg.center_offset[15]}}, cfg.center_offset} + $signed({2'b00, db});
    below = x_ext < lo;
    above = x_ext > hi;

    diff = below ? (x_ext - lo) : (x_ext - hi);
    gain = below ? cfg.negative_gain : cfg.positive_gain;
    lim  = below ? cfg.negative_limit : cfg.positive_limit;
    prod = {{16{diff[17]}}, diff} * {{18{gain[15]}}, gain};
    shifted = (cfg.effect_kind == KIND_SPRING) ? (prod >>> 8) : (prod >>> 14);

    lim_pos  = $signed({19'd0, lim});
    lim_neg  = -lim_pos;
    no_clamp = (cfg.effect_kind == KIND_INERTIA) && (lim == 15'd0);
    if (no_clamp) begin
      clamped = shifted;
    end else if (shifted > lim_pos) begin
      clamped = lim_pos;
    end else if (shifted < lim_neg) begin
      clamped = lim_neg;
    end else begin
      clamped = shifted;
    end
    banded = (below || above) ? clamped : 34'sd0;

    sign_equal = ((axis_acceleration == 16'sd0) && (axis_velocity == 16'sd0)) ||
                 ((axis_acceleration != 16'sd0) && (axis_velocity != 16'sd0) &&
                  (axis_acceleration[15] == axis_velocity[15]));

    vel_ext = {{2{axis_velocity[15]}}, axis_velocity};
    if (axis_velocity[15]) begin
      fr_coef = -{cfg.negative_gain[15], cfg.negative_gain};
      fr_t    = -vel_ext - $signed({3'b000, cfg.dead_band});
    end else begin
      fr_coef = {cfg.positive_gain[15], cfg.positive_gain};
      fr_t    = vel_ext - $signed({3'b000, cfg.dead_band});
    end
    fr_prod = $signed({18'd0, fr_t[8:0]}) * {{10{fr_coef[16]}}, fr_coef};
    if (axis_velocity == 16'sd0) begin
      fr_force = 19'sd0;
    end else if (fr_t > 18'sd256) begin
      fr_force = {{2{fr_coef[16]}}, fr_coef};
    end else if (fr_t > 18'sd0) begin
      fr_force = 19'(fr_prod >>> 8);
    end else begin
      fr_force = 19'sd0;
    end

    unique case (cfg.effect_kind)
      KIND_FRICTION: force_res = fr_force;
      KIND_INERTIA:  force_res = sign_equal ? '0 : banded[ForceWidth-1:0];
      default:       force_res = banded[ForceWidth-1:0];
    endcase
  end

endmodule

// ===== rtl/condition_force_effect_unit.sv =====
// A request passes the input register, then the result register to out_tdata.
// Throughput: one request per cycle; the input register and the result register
// each advance when the stage after them is empty or being drained.
// Reset: synchronous, active low; clears the configuration registers to zero
// and empties both pipeline stages.
// Depends on cfe_pkg, cfe_cfg_regs and cfe_force_calc.
`timescale 1ns / 1ps

module condition_force_effect_unit
  import cfe_pkg::*;
#(
  parameter int SPRING_EXTRA_DEAD_ZONE = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // [15:0] axis_position, [31:16] axis_velocity, [47:32] axis_acceleration
  input  logic [47:0]          in_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // [18:0] force_res, [23:19] zero
  output logic [23:0]          out_tdata,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  cfe_cfg_t              cfg;
  logic                  s1_valid_r;
  logic signed [15:0]    s1_pos_r;
  logic signed [15:0]    s1_vel_r;
  logic signed [15:0]    s1_acc_r;
  logic                  out_valid_r;
  logic [ForceWidth-1:0] force_r;
  logic [ForceWidth-1:0] force_nxt;
  logic                  s1_adv;

  assign pready = 1'b1;

  cfe_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  cfe_force_calc #(
    .SPRING_EXTRA_DEAD_ZONE (SPRING_EXTRA_DEAD_ZONE)
  ) u_calc (
    .cfg               (cfg),
    .axis_position     (s1_pos_r),
    .axis_velocity     (s1_vel_r),
    .axis_acceleration (s1_acc_r),
    .force_res         (force_nxt)
  );

  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_pos_r <= in_tdata[15:0];
      s1_vel_r <= in_tdata[31:16];
      s1_acc_r <= in_tdata[47:32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      force_r <= force_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, force_r};

endmodule
